[sv/decimal_text_to_fixed_point_assert.svh]
// Assertion macros for the decimal text to fixed-point parser.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DTFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dtfp_pkg.sv]
// Package: types, codes, constants and the multiply-by-ten helper of the decimal text parser.
package dtfp_pkg;

    localparam int MAX_SCALE = 18;
    localparam int EXP_LIMIT = 18;
    localparam int EXP_SAT   = 63;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_E_UP  = 8'h45;
    localparam logic [7:0] CHAR_E_LO  = 8'h65;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] PH_INT  = 2'd0;
    localparam logic [1:0] PH_FRAC = 2'd1;
    localparam logic [1:0] PH_EXP  = 2'd2;

    localparam logic [1:0] STATUS_POS = 2'd0;
    localparam logic [1:0] STATUS_NEG = 2'd1;
    localparam logic [1:0] STATUS_BAD = 2'd2;

    typedef struct packed {
        logic take;
        logic check;
        logic mul_int;
        logic div_int;
        logic quot_int;
        logic mul_setup;
        logic div_frac;
        logic mul_frac;
        logic quot_frac;
        logic sum;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic cnt_zero;
        logic frac_zero;
        logic fdig_lt;
        logic fdig_gt;
        logic div_done;
        logic out_busy;
    } sts_t;

    function automatic logic [63:0] mul10(input logic [63:0] x);
        return {x[60:0], 3'b000} + {x[62:0], 1'b0};
    endfunction

endpackage

[sv/dtfp_div.sv]
// Power-of-ten divider: repeated shift-and-add division by ten, each digit through estimate, fold and fix steps.
module dtfp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [4:0]  count,
    output logic [63:0] quotient,
    output logic        done
);
    localparam logic [1:0] STEP_EST  = 2'd0;
    localparam logic [1:0] STEP_FOLD = 2'd1;
    localparam logic [1:0] STEP_FIX  = 2'd2;

    logic [63:0] num_reg, num_next;
    logic [63:0] est_reg, est_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] est_a, est_b, est_c, est_d, est_e;
    logic [63:0] rem_est;

    assign est_a   = (num_reg >> 1) + (num_reg >> 2);
    assign est_b   = est_a + (est_a >> 4);
    assign est_c   = est_reg + (est_reg >> 8);
    assign est_d   = est_c + (est_c >> 16);
    assign est_e   = est_d + (est_d >> 32);
    assign rem_est = num_reg - ({est_reg[60:0], 3'b000} + {est_reg[62:0], 1'b0});

    always_comb
    begin
        num_next  = num_reg;
        est_next  = est_reg;
        cnt_next  = cnt_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            cnt_next  = count;
            step_next = STEP_EST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                unique case (step_reg)
                    STEP_EST:
                    begin
                        est_next  = est_b;
                        step_next = STEP_FOLD;
                    end
                    STEP_FOLD:
                    begin
                        est_next  = est_e >> 3;
                        step_next = STEP_FIX;
                    end
                    STEP_FIX:
                    begin
                        num_next  = est_reg + 64'(rem_est > 64'd9);
                        cnt_next  = cnt_reg - 1'b1;
                        step_next = STEP_EST;
                    end
                    default:
                    begin
                        step_next = STEP_EST;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            step_reg <= STEP_EST;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        est_reg <= est_next;
    end

    assign quotient = num_reg;
    assign done     = done_reg;

endmodule

[sv/dtfp_datapath.sv]
// Datapath: character decode, accumulators, scaling arithmetic and output register.
module dtfp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [4:0]         cfg_data,
    input  logic [7:0]         char_code,
    input  dtfp_pkg::cmd_t     cmd,
    input  logic               m_tready,
    output dtfp_pkg::sts_t     sts,
    output logic               out_valid,
    output logic [63:0]        out_value,
    output logic [1:0]         out_status
);
    import dtfp_pkg::*;

    logic [4:0]  scale_reg;
    logic [1:0]  phase_reg, phase_next;
    logic        first_reg, first_next;
    logic        neg_reg, neg_next;
    logic        expneg_reg, expneg_next;
    logic        signok_reg, signok_next;
    logic [63:0] int_reg, int_next;
    logic [63:0] frac_reg, frac_next;
    logic [4:0]  fdig_reg, fdig_next;
    logic [5:0]  exp_reg, exp_next;
    logic        expover_reg, expover_next;
    logic        seen_reg, seen_next;
    logic        bad_reg, bad_next;
    logic [4:0]  eff_reg, eff_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        ok_reg, ok_next;
    logic        outv_reg, outv_next;
    logic [63:0] outval_reg, outval_next;
    logic [1:0]  outst_reg, outst_next;

    logic        is_digit, is_minus, is_plus, is_e;
    logic [3:0]  digit;
    logic [9:0]  exp_trial;
    logic        exp_nz, exp_big, valid;
    logic [6:0]  eff_up, eff_dn;
    logic        div_start;
    logic [63:0] div_dividend, div_quot;
    logic [4:0]  div_count;
    logic        div_done;

    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_minus  = (char_code == CHAR_MINUS);
    assign is_plus   = (char_code == CHAR_PLUS);
    assign is_e      = (char_code == CHAR_E_UP) || (char_code == CHAR_E_LO);
    assign digit     = char_code[3:0];
    assign exp_trial = 10'(exp_reg) * 10'd10 + 10'(digit);

    assign exp_nz  = expover_reg || (exp_reg != '0);
    assign exp_big = expover_reg || (exp_reg > 6'(EXP_LIMIT));
    assign eff_up  = 7'(scale_reg) + 7'(exp_reg);
    assign eff_dn  = 7'(scale_reg) - 7'(exp_reg);

    always_comb
    begin
        valid = !bad_reg && seen_reg && (scale_reg <= 5'(MAX_SCALE))
                && !(expneg_reg && !exp_nz);
        if (exp_nz)
        begin
            if ((int_reg < 64'd1) || (int_reg > 64'd9) || exp_big)
                valid = 1'b0;
            else if (expneg_reg && (6'(scale_reg) < exp_reg))
                valid = 1'b0;
            else if (!expneg_reg && (eff_up > 7'(MAX_SCALE)))
                valid = 1'b0;
        end
    end

    always_comb
    begin
        if (!exp_nz)
            eff_next = scale_reg;
        else if (expneg_reg)
            eff_next = eff_dn[4:0];
        else
            eff_next = eff_up[4:0];
    end

    assign div_start    = cmd.div_int | cmd.div_frac;
    assign div_dividend = cmd.div_int ? int_reg : frac_reg;
    assign div_count    = cmd.div_int ? eff_reg : (fdig_reg - eff_reg);

    dtfp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .count    (div_count),
        .quotient (div_quot),
        .done     (div_done)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        neg_next     = neg_reg;
        expneg_next  = expneg_reg;
        signok_next  = signok_reg;
        int_next     = int_reg;
        frac_next    = frac_reg;
        fdig_next    = fdig_reg;
        exp_next     = exp_reg;
        expover_next = expover_reg;
        seen_next    = seen_reg;
        bad_next     = bad_reg;
        cnt_next     = cnt_reg;
        ok_next      = ok_reg;
        outv_next    = outv_reg && !m_tready;
        outval_next  = outval_reg;
        outst_next   = outst_reg;

        if (cmd.take)
        begin
            first_next = 1'b0;
            if (first_reg && is_minus)
            begin
                neg_next = 1'b1;
            end
            else if (signok_reg && (is_minus || is_plus))
            begin
                signok_next = 1'b0;
                if (is_minus)
                    expneg_next = 1'b1;
            end
            else
            begin
                signok_next = 1'b0;
                if (is_digit)
                begin
                    seen_next = 1'b1;
                    if (phase_reg == PH_INT)
                    begin
                        int_next = mul10(int_reg) + 64'(digit);
                    end
                    else if (phase_reg == PH_FRAC)
                    begin
                        if (fdig_reg < 5'(MAX_SCALE))
                        begin
                            frac_next = mul10(frac_reg) + 64'(digit);
                            fdig_next = fdig_reg + 1'b1;
                        end
                    end
                    else if (exp_trial > 10'(EXP_SAT))
                    begin
                        expover_next = 1'b1;
                        exp_next     = 6'(EXP_SAT);
                    end
                    else
                    begin
                        exp_next = exp_trial[5:0];
                    end
                end
                else if ((char_code == CHAR_DOT) && (phase_reg != PH_FRAC))
                begin
                    phase_next = PH_FRAC;
                end
                else if (is_e && (phase_reg != PH_EXP))
                begin
                    phase_next  = PH_EXP;
                    signok_next = 1'b1;
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
        end

        if (cmd.check)
        begin
            ok_next  = valid;
            cnt_next = eff_next;
        end
        if (cmd.mul_int)
        begin
            int_next = mul10(int_reg);
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.quot_int)
        begin
            int_next = div_quot;
            cnt_next = eff_reg;
        end
        if (cmd.mul_setup)
            cnt_next = eff_reg - fdig_reg;
        if (cmd.mul_frac)
        begin
            frac_next = mul10(frac_reg);
            cnt_next  = cnt_reg - 1'b1;
        end
        if (cmd.quot_frac)
            frac_next = div_quot;
        if (cmd.sum)
            int_next = int_reg + frac_reg;

        if (cmd.load_out)
        begin
            outv_next = 1'b1;
            if (ok_reg)
            begin
                outval_next = neg_reg ? (64'd0 - int_reg) : int_reg;
                outst_next  = neg_reg ? STATUS_NEG : STATUS_POS;
            end
            else
            begin
                outval_next = '0;
                outst_next  = STATUS_BAD;
            end
            phase_next   = PH_INT;
            first_next   = 1'b1;
            neg_next     = 1'b0;
            expneg_next  = 1'b0;
            signok_next  = 1'b0;
            int_next     = '0;
            frac_next    = '0;
            fdig_next    = '0;
            exp_next     = '0;
            expover_next = 1'b0;
            seen_next    = 1'b0;
            bad_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= '0;
            phase_reg   <= PH_INT;
            first_reg   <= 1'b1;
            neg_reg     <= 1'b0;
            expneg_reg  <= 1'b0;
            signok_reg  <= 1'b0;
            int_reg     <= '0;
            frac_reg    <= '0;
            fdig_reg    <= '0;
            exp_reg     <= '0;
            expover_reg <= 1'b0;
            seen_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            cnt_reg     <= '0;
            ok_reg      <= 1'b0;
            outv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                scale_reg <= cfg_data;
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            neg_reg     <= neg_next;
            expneg_reg  <= expneg_next;
            signok_reg  <= signok_next;
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            fdig_reg    <= fdig_next;
            exp_reg     <= exp_next;
            expover_reg <= expover_next;
            seen_reg    <= seen_next;
            bad_reg     <= bad_next;
            cnt_reg     <= cnt_next;
            ok_reg      <= ok_next;
            outv_reg    <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
            eff_reg <= eff_next;
        outval_reg <= outval_next;
        outst_reg  <= outst_next;
    end

    assign sts.valid     = valid;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.frac_zero = (frac_reg == '0);
    assign sts.fdig_lt   = (fdig_reg < eff_reg);
    assign sts.fdig_gt   = (fdig_reg > eff_reg);
    assign sts.div_done  = div_done;
    assign sts.out_busy  = outv_reg && !m_tready;

    assign out_valid  = outv_reg;
    assign out_value  = outval_reg;
    assign out_status = outst_reg;

endmodule

[sv/dtfp_ctrl.sv]
// Controller: sequences character intake and the end-of-string scaling steps.
module dtfp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    output logic            s_tready,
    input  dtfp_pkg::sts_t  sts,
    output dtfp_pkg::cmd_t  cmd
);
    import dtfp_pkg::*;

    localparam logic [3:0] ST_RUN   = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_MULI  = 4'd2;
    localparam logic [3:0] ST_DIVI  = 4'd3;
    localparam logic [3:0] ST_FSET  = 4'd4;
    localparam logic [3:0] ST_MULF  = 4'd5;
    localparam logic [3:0] ST_DIVF  = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;
    localparam logic [3:0] ST_MULB  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && s_tlast)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.valid ? ST_MULI : ST_DONE;
            end
            ST_MULI:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.div_int = 1'b1;
                    state_next  = ST_DIVI;
                end
                else
                begin
                    cmd.mul_int = 1'b1;
                end
            end
            ST_DIVI:
            begin
                if (sts.div_done)
                begin
                    cmd.quot_int = 1'b1;
                    state_next   = ST_MULB;
                end
            end
            ST_MULB:
            begin
                if (sts.cnt_zero)
                    state_next = ST_FSET;
                else
                    cmd.mul_int = 1'b1;
            end
            ST_FSET:
            begin
                priority if (sts.frac_zero || (!sts.fdig_lt && !sts.fdig_gt))
                begin
                    state_next = ST_SUM;
                end
                else if (sts.fdig_lt)
                begin
                    cmd.mul_setup = 1'b1;
                    state_next    = ST_MULF;
                end
                else
                begin
                    cmd.div_frac = 1'b1;
                    state_next   = ST_DIVF;
                end
            end
            ST_MULF:
            begin
                if (sts.cnt_zero)
                    state_next = ST_SUM;
                else
                    cmd.mul_frac = 1'b1;
            end
            ST_DIVF:
            begin
                if (sts.div_done)
                begin
                    cmd.quot_frac = 1'b1;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RUN;
        else
            state_reg <= state_next;
    end

endmodule

[sv/decimal_text_to_fixed_point.sv]
// Top level: ASCII decimal number stream to scaled signed 64-bit fixed-point value.
// Characters are taken one per cycle while intake is not stalled; only the last character of a string yields a result.
// After the last character the string is checked; an invalid one goes straight to the output load, a valid one
// is scaled up, divided and scaled back, its fraction aligned by multiplication or division, then summed.
// Intake stalls from the last character until the result is loaded; m_tready low extends it.
// Asynchronous active-low reset clears string state, scale register and output valid.
module decimal_text_to_fixed_point (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,     // scale_exponent
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] char_code
    input  logic        s_tlast,      // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // [63:0] fixed_value
    output logic [1:0]  m_tuser       // [1:0] status
);
    import dtfp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    dtfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dtfp_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .char_code  (s_tdata),
        .cmd        (cmd),
        .m_tready   (m_tready),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_value  (m_tdata),
        .out_status (m_tuser)
    );

`include "decimal_text_to_fixed_point_assert.svh"

    `DTFP_ASSERT_NOW(a_bad_zero, m_tvalid && (m_tuser == STATUS_BAD), m_tdata == 64'd0,
        "invalid result carries nonzero value")
    `DTFP_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3, "undefined status code")
    `DTFP_ASSERT_NEXT(a_stall_after_last, s_tvalid && s_tready && s_tlast, !s_tready,
        "intake not stalled after last character")

endmodule

[verif/decimal_text_to_fixed_point_test.sv]
// Self-checking testbench for the decimal text to fixed-point parser: directed and random number strings.
module decimal_text_to_fixed_point_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dtfp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASE_CHARS = 144;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
    } fixed_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    text_char_t    char_queue[$];
    fixed_result_t number_queue[$];
    logic [7:0]    draft[$];
    text_char_t    next_char;
    fixed_result_t oldest_number;

    logic  steady = 1'b0;
    logic  char_taken = 1'b0;
    int    chars_queued = 0;
    int    chars_taken = 0;
    int    scale_writes = 0;
    int    error_count = 0;
    int    cycle_count = 0;

    // Predictor state
    logic [4:0]  scale_setting = '0;
    logic [1:0]  cur_phase;
    logic        at_first, neg, exp_neg, sign_ok, exp_sat, any_digit, bad;
    logic [63:0] int_acc, frac_acc;
    logic [4:0]  frac_cnt;
    logic [5:0]  exp_acc;

    decimal_text_to_fixed_point DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [63:0] ten_power(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

    task automatic clear_text_state();
        cur_phase = PH_INT;
        at_first  = 1'b1;
        neg       = 1'b0;
        exp_neg   = 1'b0;
        sign_ok   = 1'b0;
        int_acc   = '0;
        frac_acc  = '0;
        frac_cnt  = '0;
        exp_acc   = '0;
        exp_sat   = 1'b0;
        any_digit = 1'b0;
        bad       = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] c);
        int t;
        if (at_first && c == CHAR_MINUS)
        begin
            at_first = 1'b0;
            neg = 1'b1;
        end
        else
        begin
            at_first = 1'b0;
            if (sign_ok && (c == CHAR_MINUS || c == CHAR_PLUS))
            begin
                sign_ok = 1'b0;
                if (c == CHAR_MINUS)
                    exp_neg = 1'b1;
            end
            else
            begin
                sign_ok = 1'b0;
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                begin
                    any_digit = 1'b1;
                    if (cur_phase == PH_INT)
                        int_acc = int_acc * 64'd10 + 64'(c - CHAR_ZERO);
                    else if (cur_phase == PH_FRAC)
                    begin
                        if (frac_cnt < MAX_SCALE)
                        begin
                            frac_acc = frac_acc * 64'd10 + 64'(c - CHAR_ZERO);
                            frac_cnt = frac_cnt + 5'd1;
                        end
                    end
                    else
                    begin
                        t = int'(exp_acc) * 10 + int'(c - CHAR_ZERO);
                        if (t > EXP_SAT)
                        begin
                            exp_sat = 1'b1;
                            t = EXP_SAT;
                        end
                        exp_acc = 6'(t);
                    end
                end
                else if (c == CHAR_DOT && cur_phase != PH_FRAC)
                    cur_phase = PH_FRAC;
                else if ((c == CHAR_E_UP || c == CHAR_E_LO) && cur_phase != PH_EXP)
                begin
                    cur_phase = PH_EXP;
                    sign_ok = 1'b1;
                end
                else
                    bad = 1'b1;
            end
        end
    endtask

    task automatic finish_number();
        int            eff;
        logic          exp_nz;
        logic          ok;
        logic [63:0]   mul, fp, ip;
        fixed_result_t r;
        eff = int'(scale_setting);
        exp_nz = exp_sat || exp_acc != 0;
        ok = 1'b1;
        if (bad || !any_digit || scale_setting > MAX_SCALE)
            ok = 1'b0;
        else if (exp_neg && !exp_nz)
            ok = 1'b0;
        else if (exp_nz)
        begin
            if (int_acc < 1 || int_acc > 9 || exp_sat || exp_acc > EXP_LIMIT)
                ok = 1'b0;
            else if (exp_neg)
            begin
                if (exp_acc > eff)
                    ok = 1'b0;
                else
                    eff = eff - int'(exp_acc);
            end
            else
            begin
                eff = eff + int'(exp_acc);
                if (eff > MAX_SCALE)
                    ok = 1'b0;
            end
        end
        r.value = '0;
        r.status = STATUS_BAD;
        if (ok)
        begin
            mul = ten_power(eff);
            fp = frac_acc;
            if (fp != 0)
            begin
                if (frac_cnt < eff)
                    fp = fp * ten_power(eff - int'(frac_cnt));
                else
                    fp = fp / ten_power(int'(frac_cnt) - eff);
            end
            ip = int_acc * mul;
            ip = (ip / mul) * mul + fp;
            r.value = neg ? -ip : ip;
            r.status = neg ? STATUS_NEG : STATUS_POS;
        end
        number_queue.push_back(r);
        clear_text_state();
    endtask

    initial
    begin
        clear_text_state();
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("decimal_text_to_fixed_point regression: fail");
            $finish;
        end
        else
            cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        char_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                scale_setting = cfg_data;
                scale_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata);
                chars_taken++;
                if (s_tlast)
                    finish_number();
            end
            if (m_tvalid && m_tready)
            begin
                if (number_queue.size() == 0)
                    flag_error($sformatf("unexpected result value=%0d status=%0d",
                                         $signed(m_tdata), m_tuser));
                else
                begin
                    oldest_number = number_queue.pop_front();
                    if (m_tdata !== oldest_number.value)
                        flag_error($sformatf("value %0d, want %0d", $signed(m_tdata),
                                             $signed(oldest_number.value)));
                    if (m_tuser !== oldest_number.status)
                        flag_error($sformatf("status %0d, want %0d", m_tuser,
                                             oldest_number.status));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || char_taken))
        begin
            if (char_queue.size() != 0 && (steady || $urandom_range(99) >= 24))
            begin
                next_char = char_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_char.code;
                s_tlast  <= next_char.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= steady || $urandom_range(99) >= 24;
    end

    task automatic queue_draft();
        foreach (draft[i])
        begin
            char_queue.push_back('{draft[i], i == draft.size() - 1});
            chars_queued++;
        end
    endtask

    task automatic queue_text(input string s);
        draft.delete();
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
        queue_draft();
    endtask

    task automatic queue_byte(input logic [7:0] c);
        draft.delete();
        draft.push_back(c);
        queue_draft();
    endtask

    task automatic add_digits(input int count);
        repeat (count)
            draft.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic build_number();
        int  r, n, v;
        logic with_exp;
        draft.delete();
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 6))
                draft.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(99) < 30)
            draft.push_back(CHAR_MINUS);
        with_exp = $urandom_range(99) < 35;
        if (with_exp && $urandom_range(3) != 0)
            draft.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
        else
        begin
            r = $urandom_range(99);
            n = r < 10 ? 0 : r < 85 ? $urandom_range(1, 3) :
                r < 95 ? $urandom_range(4, 12) : $urandom_range(17, 21);
            add_digits(n);
        end
        if ($urandom_range(1) == 1)
        begin
            draft.push_back(CHAR_DOT);
            r = $urandom_range(99);
            n = r < 80 ? $urandom_range(0, 4) : r < 92 ? $urandom_range(5, 17) :
                $urandom_range(18, 22);
            add_digits(n);
        end
        if (with_exp)
        begin
            draft.push_back($urandom_range(1) == 1 ? CHAR_E_UP : CHAR_E_LO);
            r = $urandom_range(2);
            if (r == 1)
                draft.push_back(CHAR_PLUS);
            else if (r == 2)
                draft.push_back(CHAR_MINUS);
            if ($urandom_range(99) < 80)
            begin
                v = $urandom_range(20);
                if (v >= 10)
                    draft.push_back(CHAR_ZERO + 8'(v / 10));
                draft.push_back(CHAR_ZERO + 8'(v % 10));
            end
            else
                add_digits($urandom_range(1, 3));
        end
        if (draft.size() == 0)
            add_digits(1);
        if ($urandom_range(99) < 10)
        begin
            r = $urandom_range(5);
            n = $urandom_range(draft.size() - 1);
            case (r)
                0: draft[n] = CHAR_DOT;
                1: draft[n] = CHAR_E_LO;
                2: draft[n] = CHAR_E_UP;
                3: draft[n] = CHAR_PLUS;
                4: draft[n] = CHAR_MINUS;
                default: draft[n] = 8'($urandom_range(255));
            endcase
        end
    endtask

    task automatic queue_random_numbers(input int budget);
        int added;
        added = 0;
        while (added < budget)
        begin
            build_number();
            added += draft.size();
            queue_draft();
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (chars_taken != chars_queued || number_queue.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_scale(input logic [4:0] v);
        int n;
        @(negedge clk);
        n = scale_writes;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (scale_writes == n);
        cfg_valid <= 1'b0;
    endtask

    logic [4:0] scale_plan[8] = '{5'd0, 5'd18, 5'd5, 5'd31, 5'd12, 5'd19, 5'd1, 5'd9};

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_scale(5'd3);
        queue_text("-");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_text("-9");
        queue_text("1.5");
        queue_text("1..");
        queue_text("2e-3");
        queue_text("3E+1");
        queue_text("1e-0");
        queue_text("5e0");
        queue_text("1e2.5");
        wait_idle();

        foreach (scale_plan[k])
        begin
            write_scale(scale_plan[k]);
            steady <= (k == 2);
            queue_random_numbers(PHASE_CHARS);
            wait_idle();
        end

        if (number_queue.size() != 0)
            flag_error($sformatf("%0d results never arrived", number_queue.size()));
        if (error_count == 0)
            $display("decimal_text_to_fixed_point regression: pass");
        else
            $display("decimal_text_to_fixed_point regression: fail");
        $finish;
    end

endmodule
